// File: src/tare_pkg.sv
`timescale 1ns / 1ps

package tare_pkg;

    localparam int FRAC_BITS = 16;

    // field widths
    localparam int Q_W        = 17;
    localparam int DT_W       = 20;
    localparam int ATK_W      = 20;
    localparam int REL_W      = 23;
    localparam int PHASE_W    = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // datapath widths
    localparam int MUL_A_W      = DT_W;
    localparam int MUL_B_W      = Q_W + 1;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int ENV_DIVD_W   = DT_W + FRAC_BITS;
    localparam int DIVS_W       = REL_W;

    // drift step dt*speed/2500000: 2500000 = 32 * 78125, so drop five bits
    // and multiply by ceil(2^47 / 78125); exact for dt*speed below 2^36
    localparam int DRIFT_PRE_SHIFT   = 5;
    localparam int DRIFT_Y_W         = 31;
    localparam int DRIFT_RECIP_W     = 31;
    localparam int DRIFT_RECIP_SHIFT = 47;
    localparam int DRIFT_Q_W         = 15;
    localparam int DRIFT_PROD_W      = DRIFT_Y_W + DRIFT_RECIP_W;
    localparam logic [DRIFT_RECIP_W-1:0] DRIFT_RECIP = 31'd1801439851;

    localparam logic [Q_W-1:0]     ONE        = Q_W'(64'd1 << FRAC_BITS);
    localparam logic [Q_W:0]       THREE_ONE  = (Q_W + 1)'(64'd3 << FRAC_BITS);
    localparam logic [REL_W-1:0]   INSTANT_US = REL_W'(100);
    localparam logic [PHASE_W-1:0] PHASE_LIMIT =
        PHASE_W'(64'd1000000 << FRAC_BITS);
    localparam logic [PHASE_W-1:0] PHASE_WRAP_MASK =
        PHASE_W'((64'd1024 << FRAC_BITS) - 64'd1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd4;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DRIFT,
        MUL_SQUARE,
        MUL_EASE,
        MUL_FLOOR,
        MUL_GAIN
    } t_mul_op;

    typedef struct packed {
        logic    in_load;
        t_mul_op mul_op;
        logic    div_start;
        logic    env_update;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_dp_status;

    function automatic logic [Q_W-1:0] sat_one(input logic [Q_W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

endpackage

// File: src/tare_in_if.sv
`timescale 1ns / 1ps

interface tare_in_if;
    import tare_pkg::*;

    logic                valid;
    logic                ready;
    logic [DT_W-1:0]     dt_us;
    logic                gate_level;
    logic                trigger_level;

    modport source (output valid, output dt_us, output gate_level,
                    output trigger_level, input ready);
    modport sink   (input valid, input dt_us, input gate_level,
                    input trigger_level, output ready);
endinterface

// File: src/tare_out_if.sv
`timescale 1ns / 1ps

interface tare_out_if;
    import tare_pkg::*;

    logic                valid;
    logic                ready;
    logic [Q_W-1:0]      wobble_gain;
    logic [Q_W-1:0]      envelope_level;
    logic [PHASE_W-1:0]  drift_phase;

    modport source (output valid, output wobble_gain, output envelope_level,
                    output drift_phase, input ready);
    modport sink   (input valid, input wobble_gain, input envelope_level,
                    input drift_phase, output ready);
endinterface

// File: src/tare_div.sv
`timescale 1ns / 1ps

module tare_div #(
    parameter int DIVD_W = 36,
    parameter int DIVS_W = 23
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [DIVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_work;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_divisor;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [DIVS_W:0]   rem_sh;
    logic              ge;
    logic [DIVS_W:0]   diff;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh = {r_rem, r_work[DIVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_divisor};
    assign diff   = rem_sh - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_cnt     <= CNT_W'(DIVD_W);
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[DIVD_W-2:0], ge};
            r_rem  <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            r_cnt  <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_work;

endmodule

// File: src/tare_ctrl.sv
`timescale 1ns / 1ps

module tare_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tare_pkg::t_dp_status i_status,
    output tare_pkg::t_dp_cmd    o_cmd
);
    import tare_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DRIFT,
        S_DIV_START,
        S_DIV_WAIT,
        S_ENV,
        S_SQUARE,
        S_EASE,
        S_FLOOR,
        S_GAIN,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.mul_op     = MUL_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_MUL_DRIFT;
                end
            end
            S_MUL_DRIFT: begin
                o_cmd.mul_op = MUL_DRIFT;
                n_state      = S_DIV_START;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_ENV;
                end
            end
            S_ENV: begin
                o_cmd.env_update = 1'b1;
                n_state          = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.mul_op = MUL_SQUARE;
                n_state      = S_EASE;
            end
            S_EASE: begin
                o_cmd.mul_op = MUL_EASE;
                n_state      = S_FLOOR;
            end
            S_FLOOR: begin
                o_cmd.mul_op = MUL_FLOOR;
                n_state      = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul_op = MUL_GAIN;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // hold until the previous result has been taken
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: src/tare_dp.sv
`timescale 1ns / 1ps

module tare_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tare_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tare_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [tare_pkg::DT_W-1:0]       i_dt_us,
    input  logic                            i_gate_level,
    input  logic                            i_trigger_level,
    input  tare_pkg::t_dp_cmd               i_cmd,
    output tare_pkg::t_dp_status            o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [tare_pkg::Q_W-1:0]        o_wobble_gain,
    output logic [tare_pkg::Q_W-1:0]        o_envelope_level,
    output logic [tare_pkg::PHASE_W-1:0]    o_drift_phase
);
    import tare_pkg::*;

    // configuration
    logic [Q_W-1:0]   r_amount;
    logic [Q_W-1:0]   r_intensity;
    logic [Q_W-1:0]   r_speed;
    logic [ATK_W-1:0] r_attack;
    logic [REL_W-1:0] r_release;

    // state
    logic [Q_W-1:0]     r_env;
    logic [PHASE_W-1:0] r_phase;
    logic               r_trig_run;
    logic               r_gate_prev;
    logic               r_trig_prev;

    // per item
    logic [DT_W-1:0]      r_dt;
    logic                 r_up;
    logic [PROD_W-1:0]    r_prod;
    logic [DRIFT_Q_W-1:0] r_drift_q;

    // output register
    logic               r_out_valid;
    logic [Q_W-1:0]     r_out_gain;
    logic [Q_W-1:0]     r_out_env;
    logic [PHASE_W-1:0] r_out_phase;

    logic                    os_after_gate;
    logic                    n_trig_run;
    logic [MUL_A_W-1:0]      op_a;
    logic [MUL_B_W-1:0]      op_b;
    logic [PROD_W-1:0]       n_prod;
    logic [Q_W-1:0]          prod_q;
    logic [DIVS_W-1:0]       env_divisor;
    logic [ENV_DIVD_W-1:0]   q_env;
    logic                    env_busy;
    logic [DRIFT_PROD_W-1:0] drift_prod;
    logic [ENV_DIVD_W:0]     env_sum;
    logic [PHASE_W+1:0]      phase_sum;
    logic [PHASE_W+1:0]      phase_wrapped;

    // edge rules, gate before trigger
    assign os_after_gate = (i_gate_level && !r_gate_prev) ? 1'b0 : r_trig_run;
    assign n_trig_run    = (i_trigger_level && !r_trig_prev) ? 1'b1 : os_after_gate;

    // Q-scaled slice of the last product
    assign prod_q = r_prod[FRAC_BITS +: Q_W];

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.mul_op)
            MUL_DRIFT: begin
                op_a = r_dt;
                op_b = {1'b0, sat_one(r_speed)};
            end
            MUL_SQUARE: begin
                op_a = MUL_A_W'(r_env);
                op_b = {1'b0, r_env};
            end
            MUL_EASE: begin
                op_a = MUL_A_W'(prod_q);
                op_b = THREE_ONE - {r_env, 1'b0};
            end
            MUL_FLOOR: begin
                op_a = MUL_A_W'(ONE - sat_one(r_amount));
                op_b = {1'b0, ONE - prod_q};
            end
            MUL_GAIN: begin
                op_a = MUL_A_W'(ONE - prod_q);
                op_b = {1'b0, sat_one(r_intensity)};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign n_prod = PROD_W'(op_a) * PROD_W'(op_b);

    assign env_divisor = r_up ? DIVS_W'(r_attack) : r_release;

    tare_div #(
        .DIVD_W (ENV_DIVD_W),
        .DIVS_W (DIVS_W)
    ) u_env_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_dt, FRAC_BITS'(0)}),
        .i_divisor  (env_divisor),
        .o_busy     (env_busy),
        .o_quotient (q_env)
    );

    // drift step by reciprocal multiply of the dt*speed product
    assign drift_prod = DRIFT_PROD_W'(r_prod[DRIFT_PRE_SHIFT +: DRIFT_Y_W])
                      * DRIFT_PROD_W'(DRIFT_RECIP);

    assign env_sum       = (ENV_DIVD_W + 1)'(r_env) + (ENV_DIVD_W + 1)'(q_env);
    assign phase_sum     = (PHASE_W + 2)'(r_phase) + (PHASE_W + 2)'(r_drift_q);
    assign phase_wrapped = (phase_sum > (PHASE_W + 2)'(PHASE_LIMIT))
                         ? (phase_sum & (PHASE_W + 2)'(PHASE_WRAP_MASK))
                         : phase_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount    <= '0;
            r_intensity <= Q_W'(26214);
            r_speed     <= Q_W'(16384);
            r_attack    <= '0;
            r_release   <= REL_W'(500000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AMOUNT:    r_amount    <= i_cfg_data[Q_W-1:0];
                CFG_INTENSITY: r_intensity <= i_cfg_data[Q_W-1:0];
                CFG_SPEED:     r_speed     <= i_cfg_data[Q_W-1:0];
                CFG_ATTACK:    r_attack    <= i_cfg_data[ATK_W-1:0];
                CFG_RELEASE:   r_release   <= i_cfg_data[REL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env       <= '0;
            r_phase     <= '0;
            r_trig_run  <= 1'b0;
            r_gate_prev <= 1'b0;
            r_trig_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.in_load) begin
                r_trig_run  <= n_trig_run;
                r_gate_prev <= i_gate_level;
                r_trig_prev <= i_trigger_level;
            end
            if (i_cmd.env_update) begin
                if (r_up) begin
                    // saturate at full and drop the trigger run
                    if ((r_attack <= ATK_W'(INSTANT_US))
                            || (env_sum >= (ENV_DIVD_W + 1)'(ONE))) begin
                        r_env      <= ONE;
                        r_trig_run <= 1'b0;
                    end else begin
                        r_env <= env_sum[Q_W-1:0];
                    end
                end else begin
                    if (r_release <= INSTANT_US) begin
                        r_env <= '0;
                    end else if (ENV_DIVD_W'(r_env) > q_env) begin
                        r_env <= r_env - q_env[Q_W-1:0];
                    end else begin
                        r_env <= '0;
                    end
                end
                r_phase <= phase_wrapped[PHASE_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_dt <= i_dt_us;
            r_up <= i_gate_level || n_trig_run;
        end
        if (i_cmd.mul_op != MUL_NONE) begin
            r_prod <= n_prod;
        end
        if (i_cmd.div_start) begin
            r_drift_q <= drift_prod[DRIFT_RECIP_SHIFT +: DRIFT_Q_W];
        end
        if (i_cmd.out_load) begin
            r_out_gain  <= prod_q;
            r_out_env   <= r_env;
            r_out_phase <= r_phase;
        end
    end

    assign o_status.div_busy = env_busy;
    assign o_status.out_full = r_out_valid;

    assign o_out_valid      = r_out_valid;
    assign o_wobble_gain    = r_out_gain;
    assign o_envelope_level = r_out_env;
    assign o_drift_phase    = r_out_phase;

    a_env_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= ONE)
        else $error("envelope above full scale");

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_LIMIT)
        else $error("drift phase above wrap limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("result loaded over an untaken item");

    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> env_busy)
        else $error("divider did not start");

    a_full_clears_trig_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.env_update && r_up && (r_attack <= ATK_W'(INSTANT_US))) |=>
            (r_env == ONE && !r_trig_run))
        else $error("instant attack did not reach full");

endmodule

// File: src/triggered_attack_release_envelope_top.sv
`timescale 1ns / 1ps

// Attack-release envelope driven by gate and trigger ticks.
//
// Input channel i_in carries one tick per item: dt_us, gate_level and
// trigger_level. Output channel o_out returns one result item per tick:
// the eased gain, the raw envelope and the drift phase after the update.
// Both channels use valid/ready; an item moves when both are high.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data while no item is in flight; an unknown index is ignored.
//
// Each item moves from acceptance through the drift multiply, the 36-step
// restoring divider for the envelope ramp, the envelope update, four passes
// through one shared multiplier that finish the gain, and the output load; a
// new item is accepted only once the last one is loaded. The drift step comes
// from a reciprocal multiply beside the divider.
// A finished result sits in the output register; while the receiver stalls
// the block completes the next item and then holds it until o_out is free.
// Synchronous reset clears the envelope, phase, edge history and trigger
// run flag and restores the register defaults.

module triggered_attack_release_envelope_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tare_in_if.sink                         i_in,
    tare_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [tare_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tare_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tare_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    tare_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tare_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_dt_us          (i_in.dt_us),
        .i_gate_level     (i_in.gate_level),
        .i_trigger_level  (i_in.trigger_level),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_wobble_gain    (o_out.wobble_gain),
        .o_envelope_level (o_out.envelope_level),
        .o_drift_phase    (o_out.drift_phase)
    );

    assign i_in.ready = in_ready;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tare_pkg::*;

    localparam logic [63:0] FULL_SCALE       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] INSTANT_LIMIT_US = 64'd100;
    localparam logic [63:0] DRIFT_DIVISOR    = 64'd2500000;
    localparam logic [63:0] PHASE_CEILING    = 64'd1000000 << FRAC_BITS;
    localparam logic [63:0] PHASE_FOLD       = (64'd1024 << FRAC_BITS) - 64'd1;
    localparam logic [63:0] PHASE_KEEP       = (64'd1 << PHASE_W) - 64'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 3'd7;

    localparam int RUN_LIMIT         = 1500000;
    localparam int DRAIN_CYCLES      = 60;
    localparam int ITEMS_PER_SETTING = 106;
    localparam int MAX_GAP           = 60;
    localparam int REPORT_LIMIT      = 10;

    typedef struct packed {
        logic [Q_W-1:0]     gain;
        logic [Q_W-1:0]     level;
        logic [PHASE_W-1:0] phase;
    } t_env_out;

    typedef enum logic {
        ROW_TICK,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  gate;
        logic                  trig;
        logic                  typed;
        t_env_out              want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tare_in_if  tick_ch();
    tare_out_if result_ch();

    triggered_attack_release_envelope_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tick_ch),
        .o_out       (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // configuration copy and envelope state
    logic [Q_W-1:0]   amount_reg;
    logic [Q_W-1:0]   intensity_reg;
    logic [Q_W-1:0]   speed_reg;
    logic [ATK_W-1:0] attack_reg;
    logic [REL_W-1:0] release_reg;
    logic [63:0]      env_level;
    logic [63:0]      phase_sum;
    logic             trig_run;
    logic             gate_was;
    logic             trig_was;

    t_env_out env_out_due[$];
    int       mismatch_count;
    int       cycle_count;
    int       sender_idle_pct;
    int       receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] clamp_full(input logic [Q_W-1:0] v);
        return (64'(v) > FULL_SCALE) ? FULL_SCALE : 64'(v);
    endfunction

    function automatic t_env_out advance_envelope(input logic [DT_W-1:0] dt,
                                                  input logic gate, input logic trig);
        logic [63:0] dt_q;
        logic [63:0] ramp;
        logic [63:0] sq;
        logic [63:0] eased;
        logic [63:0] floored;
        t_env_out    r;

        // gate edge first, then trigger edge
        if (gate && !gate_was)
            trig_run = 1'b0;
        gate_was = gate;
        if (trig && !trig_was)
            trig_run = 1'b1;
        trig_was = trig;

        dt_q = 64'(dt) << FRAC_BITS;
        if (gate || trig_run) begin
            if (64'(attack_reg) <= INSTANT_LIMIT_US)
                env_level = FULL_SCALE;
            else
                env_level = env_level + dt_q / 64'(attack_reg);
            if (env_level >= FULL_SCALE) begin
                env_level = FULL_SCALE;
                trig_run  = 1'b0;
            end
        end else if (64'(release_reg) <= INSTANT_LIMIT_US) begin
            env_level = 64'd0;
        end else begin
            ramp      = dt_q / 64'(release_reg);
            env_level = (env_level > ramp) ? env_level - ramp : 64'd0;
        end

        sq      = (env_level * env_level) >> FRAC_BITS;
        eased   = (sq * (3 * FULL_SCALE - 2 * env_level)) >> FRAC_BITS;
        floored = FULL_SCALE -
                  (((FULL_SCALE - clamp_full(amount_reg)) * (FULL_SCALE - eased)) >> FRAC_BITS);

        phase_sum = phase_sum + (64'(dt) * clamp_full(speed_reg)) / DRIFT_DIVISOR;
        if (phase_sum > PHASE_CEILING)
            phase_sum = phase_sum & PHASE_FOLD;
        phase_sum = phase_sum & PHASE_KEEP;

        r.gain  = Q_W'((floored * clamp_full(intensity_reg)) >> FRAC_BITS);
        r.level = Q_W'(env_level);
        r.phase = PHASE_W'(phase_sum);
        return r;
    endfunction

    function automatic t_row tick_row(input logic [DT_W-1:0] dt, input logic gate,
                                      input logic trig);
        t_row r;
        r       = '0;
        r.kind  = ROW_TICK;
        r.value = CFG_DATA_W'(dt);
        r.gate  = gate;
        r.trig  = trig;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [DT_W-1:0] dt, input logic gate,
                                       input logic trig, input logic [Q_W-1:0] gain,
                                       input logic [Q_W-1:0] level,
                                       input logic [PHASE_W-1:0] phase);
        t_row r;
        r            = tick_row(dt, gate, trig);
        r.typed      = 1'b1;
        r.want.gain  = gain;
        r.want.level = level;
        r.want.phase = phase;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] value);
        t_row r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_AMOUNT:    amount_reg    = value[Q_W-1:0];
            CFG_INTENSITY: intensity_reg = value[Q_W-1:0];
            CFG_SPEED:     speed_reg     = value[Q_W-1:0];
            CFG_ATTACK:    attack_reg    = value[ATK_W-1:0];
            CFG_RELEASE:   release_reg   = value[REL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // hold the input channel quiet until every outstanding result is back
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (env_out_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_tick(input logic [DT_W-1:0] dt, input logic gate, input logic trig,
                             input logic typed, input t_env_out want);
        int       gap;
        t_env_out predicted;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid         <= 1'b1;
        tick_ch.dt_us         <= dt;
        tick_ch.gate_level    <= gate;
        tick_ch.trigger_level <= trig;
        do @(posedge i_clk); while (!tick_ch.ready);
        predicted = advance_envelope(dt, gate, trig);
        env_out_due.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic randomize_config();
        logic [Q_W-1:0]   frac[3];
        logic [ATK_W-1:0] atk;
        logic [REL_W-1:0] rel;
        foreach (frac[i]) begin
            case ($urandom_range(0, 4))
                0: frac[i] = '0;
                1: frac[i] = Q_W'(FULL_SCALE);
                2: frac[i] = '1;
                3: frac[i] = Q_W'($urandom);
                default: frac[i] = Q_W'($urandom_range(0, 65536));
            endcase
        end
        case ($urandom_range(0, 4))
            0: atk = ATK_W'($urandom_range(0, 100));
            1: atk = ATK_W'($urandom_range(101, 3000));
            2: atk = ATK_W'($urandom_range(3001, 100000));
            3: atk = ATK_W'($urandom_range(100001, 1000000));
            default: atk = '1;
        endcase
        case ($urandom_range(0, 4))
            0: rel = REL_W'($urandom_range(0, 100));
            1: rel = REL_W'($urandom_range(101, 5000));
            2: rel = REL_W'($urandom_range(5001, 300000));
            3: rel = REL_W'($urandom_range(300001, 5000000));
            default: rel = '1;
        endcase
        // junk in the unused upper data bits must be dropped
        write_reg(CFG_AMOUNT,    {(CFG_DATA_W - Q_W)'($urandom), frac[0]});
        write_reg(CFG_INTENSITY, {(CFG_DATA_W - Q_W)'($urandom), frac[1]});
        write_reg(CFG_SPEED,     {(CFG_DATA_W - Q_W)'($urandom), frac[2]});
        write_reg(CFG_ATTACK,    {(CFG_DATA_W - ATK_W)'($urandom), atk});
        write_reg(CFG_RELEASE,   rel);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LOW, CFG_SPARE_HIGH)),
                      CFG_DATA_W'($urandom));
    endtask

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, label, want, got);
        end
    endtask

    // stall the receiver in the given share of cycles
    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_env_out want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (env_out_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result item with nothing outstanding", $realtime);
            end else begin
                want = env_out_due.pop_front();
                check_field("wobble_gain",    64'(want.gain),  64'(result_ch.wobble_gain));
                check_field("envelope_level", 64'(want.level), 64'(result_ch.envelope_level));
                check_field("drift_phase",    64'(want.phase), 64'(result_ch.drift_phase));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_row            plan[$];
        t_row            r;
        logic [DT_W-1:0] dt;
        logic            gate;
        logic            trig;
        int              dt_ceiling;
        int              send_pct[4];
        int              stall_pct[4];

        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.dt_us         = '0;
        tick_ch.gate_level    = 1'b0;
        tick_ch.trigger_level = 1'b0;
        result_ch.ready       = 1'b0;
        mismatch_count        = 0;
        cycle_count           = 0;
        sender_idle_pct       = 0;
        receiver_stall_pct    = 0;

        amount_reg    = '0;
        intensity_reg = Q_W'(26214);
        speed_reg     = Q_W'(16384);
        attack_reg    = '0;
        release_reg   = REL_W'(500000);
        env_level     = '0;
        phase_sum     = '0;
        trig_run      = 1'b0;
        gate_was      = 1'b0;
        trig_was      = 1'b0;

        // register defaults: idle tick, then instant attack on gate
        plan.push_back(typed_row(20'd0, 1'b0, 1'b0, 17'd0, 17'd0, 36'd0));
        plan.push_back(typed_row(20'd0, 1'b1, 1'b0, 17'd26214, 17'd65536, 36'd0));
        plan.push_back(tick_row(20'd1000000, 1'b1, 1'b0));
        plan.push_back(tick_row('1, 1'b0, 1'b0));
        // times at the instant threshold
        plan.push_back(cfg_row(CFG_ATTACK, 23'd100));
        plan.push_back(cfg_row(CFG_RELEASE, 23'd100));
        plan.push_back(tick_row(20'd0, 1'b0, 1'b1));
        plan.push_back(tick_row(20'd5, 1'b0, 1'b1));
        // just above it, fractions at full
        plan.push_back(cfg_row(CFG_ATTACK, 23'd101));
        plan.push_back(cfg_row(CFG_RELEASE, 23'd101));
        plan.push_back(cfg_row(CFG_AMOUNT, 23'd65536));
        plan.push_back(cfg_row(CFG_INTENSITY, 23'd65536));
        plan.push_back(cfg_row(CFG_SPEED, 23'd65536));
        plan.push_back(tick_row(20'd50, 1'b0, 1'b0));
        plan.push_back(tick_row(20'd50, 1'b0, 1'b1));
        plan.push_back(tick_row(20'd50, 1'b1, 1'b1));
        plan.push_back(tick_row(20'd0, 1'b1, 1'b0));
        plan.push_back(tick_row(20'd10, 1'b0, 1'b0));
        // longest times, fractions above full, writes to unused indexes
        plan.push_back(cfg_row(CFG_ATTACK, 23'hFFFFF));
        plan.push_back(cfg_row(CFG_RELEASE, '1));
        plan.push_back(cfg_row(CFG_AMOUNT, 23'h1FFFF));
        plan.push_back(cfg_row(CFG_INTENSITY, 23'h1FFFF));
        plan.push_back(cfg_row(CFG_SPEED, 23'h1FFFF));
        plan.push_back(cfg_row(CFG_SPARE_LOW, '1));
        plan.push_back(cfg_row(CFG_SPARE_HIGH, '0));
        plan.push_back(tick_row('1, 1'b1, 1'b1));
        plan.push_back(tick_row('1, 1'b0, 1'b0));
        plan.push_back(tick_row(20'd1000, 1'b0, 1'b0));
        // triggered ramps, gate taking over and letting go
        plan.push_back(cfg_row(CFG_ATTACK, 23'd200000));
        plan.push_back(cfg_row(CFG_RELEASE, 23'd300000));
        plan.push_back(cfg_row(CFG_AMOUNT, 23'h8000));
        plan.push_back(cfg_row(CFG_INTENSITY, 23'd0));
        plan.push_back(cfg_row(CFG_SPEED, 23'd0));
        plan.push_back(tick_row(20'd100000, 1'b0, 1'b1));
        plan.push_back(tick_row(20'd100000, 1'b1, 1'b1));
        plan.push_back(tick_row(20'd100000, 1'b0, 1'b0));
        plan.push_back(tick_row(20'd100000, 1'b0, 1'b1));
        plan.push_back(tick_row(20'd50000, 1'b0, 1'b1));
        plan.push_back(tick_row(20'd200000, 1'b0, 1'b0));
        plan.push_back(tick_row(20'hAAAAA, 1'b1, 1'b0));
        plan.push_back(tick_row(20'h55555, 1'b0, 1'b1));

        send_pct  = '{0, 68, 0, 18};
        stall_pct = '{0, 0, 68, 18};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            r = plan[i];
            if (r.kind == ROW_CFG) begin
                settle();
                write_reg(r.reg_idx, r.value);
            end else begin
                send_tick(r.value[DT_W-1:0], r.gate, r.trig, r.typed, r.want);
            end
        end

        gate = 1'b0;
        trig = 1'b0;
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct    = send_pct[p];
            receiver_stall_pct = stall_pct[p];
            for (int s = 0; s < 4; s++) begin
                settle();
                randomize_config();
                case ($urandom_range(0, 3))
                    0: dt_ceiling = 300;
                    1: dt_ceiling = 8000;
                    2: dt_ceiling = 150000;
                    default: dt_ceiling = 20'hFFFFF;
                endcase
                for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                    case ($urandom_range(0, 19))
                        0: dt = '0;
                        1: dt = '1;
                        default: dt = DT_W'($urandom_range(0, dt_ceiling));
                    endcase
                    // mostly held levels with occasional edges, some noise
                    if ($urandom_range(0, 9) == 0) begin
                        gate = 1'($urandom);
                        trig = 1'($urandom);
                    end else begin
                        if ($urandom_range(0, 7) == 0)
                            gate = ~gate;
                        if ($urandom_range(0, 3) == 0)
                            trig = ~trig;
                    end
                    send_tick(dt, gate, trig, 1'b0, '0);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        mismatch_count += env_out_due.size();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/tare_pkg.sv
src/tare_in_if.sv
src/tare_out_if.sv
src/tare_div.sv
src/tare_ctrl.sv
src/tare_dp.sv
src/triggered_attack_release_envelope_top.sv
verif/testbench.sv
